// ===== rtl/core/assert_macros.svh =====
// assertion macros used by line_follow_corner_supervisor_unit
// no dependencies; the user must have clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define LFCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define LFCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/lfcs_pkg.sv =====
// types, codes and helpers for the line follow corner supervisor
// used by lfcs_step and line_follow_corner_supervisor_unit
`timescale 1ns / 1ps

package lfcs_pkg;

  localparam int unsigned DutyW  = 7;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DutyW-1:0]  DutyMax  = 7'd100;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FOLLOW_DUTY   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INNER_DUTY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_APPROACH_DUTY = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CORNER_CONFIRM = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOST_CONFIRM  = 3'd4;

  // reset values of the configuration registers
  localparam logic [DutyW-1:0]  FollowDutyRst  = 7'd60;
  localparam logic [DutyW-1:0]  InnerDutyRst   = 7'd20;
  localparam logic [DutyW-1:0]  ApproachDutyRst = 7'd30;
  localparam logic [CountW-1:0] CornerConfirmRst = 16'd4;
  localparam logic [CountW-1:0] LostConfirmRst = 16'd20;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_HALT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOPPED   = 2'd0,
    MODE_FOLLOWING = 2'd1,
    MODE_TURNING   = 2'd2,
    MODE_FAULTED   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    TS_IDLE  = 2'd0,
    TS_BUSY  = 2'd1,
    TS_DONE  = 2'd2,
    TS_FAULT = 2'd3
  } turn_status_t;

  // turn direction, shared by candidate direction and turn request
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  localparam logic [2:0] FAULT_NONE  = 3'd0;
  localparam logic [2:0] FAULT_TURN  = 3'd1;
  localparam logic [2:0] FAULT_AMBIG = 3'd2;
  localparam logic [2:0] FAULT_REQ   = 3'd3;
  localparam logic [2:0] FAULT_LOST  = 3'd4;

  typedef struct packed {
    logic [DutyW-1:0]  follow_duty;
    logic [DutyW-1:0]  inner_duty;
    logic [DutyW-1:0]  approach_duty;
    logic [CountW-1:0] corner_confirm_count;
    logic [CountW-1:0] lost_confirm_count;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [2:0]        fault;
    logic [CountW-1:0] turn_total;
    logic              armed;
    logic [1:0]        cand_dir;
    logic [CountW-1:0] cand_run;
    logic [CountW-1:0] clear_run;
    logic [CountW-1:0] ambig_run;
    logic [CountW-1:0] lost_run;
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       fl;
    logic       fr;
    logic       fml;
    logic       fmr;
    logic       rml;
    logic       rmr;
    logic [1:0] turn_status;
    logic       turn_accepts;
    logic [2:0] halt_reason;
  } item_t;

  typedef struct packed {
    logic              motor_update;
    logic [DutyW-1:0]  left_duty;
    logic [DutyW-1:0]  right_duty;
    logic [1:0]        turn_request;
    logic              turn_reset_pulse;
    logic [1:0]        mode;
    logic [2:0]        fault_code;
    logic [CountW-1:0] turns_done;
    logic              start_accepted;
  } result_t;

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] c);
    return (c == CountMax) ? c : c + 16'd1;
  endfunction

  function automatic logic [DutyW-1:0] clamp_duty(logic [DutyW-1:0] d);
    return (d > DutyMax) ? DutyMax : d;
  endfunction

endpackage

// ===== rtl/core/lfcs_step.sv =====
// next state and result word for one item of the supervisor
// purely combinational; depends on lfcs_pkg
`timescale 1ns / 1ps

module lfcs_step import lfcs_pkg::*; (
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res
);

  logic [DutyW-1:0]  fol_d, inn_d, app_d;
  logic [DutyW-1:0]  steer_l, steer_r;
  logic [CountW-1:0] amb_inc, cand_inc, clear_inc, lost_inc;
  logic [1:0]        dir;
  logic              lost_pat, clear_pat;

  assign fol_d = clamp_duty(cfg.follow_duty);
  assign inn_d = clamp_duty(cfg.inner_duty);
  assign app_d = clamp_duty(cfg.approach_duty);

  // priority steering while following
  always_comb begin
    if (item.fml && item.fmr) begin
      steer_l = fol_d;
      steer_r = fol_d;
    end else if (item.fml) begin
      steer_l = inn_d;
      steer_r = fol_d;
    end else if (item.fmr) begin
      steer_l = fol_d;
      steer_r = inn_d;
    end else if (item.rml && item.rmr) begin
      steer_l = app_d;
      steer_r = app_d;
    end else begin
      steer_l = '0;
      steer_r = '0;
    end
  end

  always_comb begin
    if (item.rml && item.rmr && item.fl) begin
      dir = DIR_LEFT;
    end else if (item.rml && item.rmr && item.fr) begin
      dir = DIR_RIGHT;
    end else begin
      dir = DIR_NONE;
    end
  end

  assign lost_pat  = !item.fml && !item.fmr && !(item.rml && item.rmr);
  assign clear_pat = !item.fl && !item.fr && item.fml && item.fmr && item.rml && item.rmr;
  assign amb_inc   = sat_inc(st.ambig_run);
  assign cand_inc  = sat_inc((st.cand_dir == dir) ? st.cand_run : '0);
  assign clear_inc = sat_inc(st.clear_run);
  assign lost_inc  = sat_inc(st.lost_run);

  always_comb begin
    logic go_lost;
    logic [2:0] reason;
    go_lost = 1'b0;
    reason  = (item.halt_reason > FAULT_LOST) ? FAULT_LOST : item.halt_reason;
    st_nxt  = st;
    res     = '0;

    unique case (cmd_t'(item.cmd))
      CMD_TICK: begin
        if (st.mode == MODE_STOPPED || st.mode == MODE_FAULTED) begin
          res.motor_update = 1'b1;
        end else begin
          unique case (turn_status_t'(item.turn_status))
            TS_FAULT: begin
              st_nxt.fault = FAULT_TURN;
              st_nxt.mode  = MODE_FAULTED;
              res.motor_update = 1'b1;
            end
            TS_DONE: begin
              st_nxt.turn_total = sat_inc(st.turn_total);
              st_nxt.mode      = MODE_FOLLOWING;
              st_nxt.armed     = 1'b0;
              st_nxt.cand_dir  = DIR_NONE;
              st_nxt.cand_run  = '0;
              st_nxt.clear_run = '0;
              st_nxt.ambig_run = '0;
              st_nxt.lost_run  = '0;
              res.turn_reset_pulse = 1'b1;
            end
            TS_BUSY: begin
              st_nxt.mode = MODE_TURNING;
            end
            default: begin
              if (st.armed) begin
                if (item.fl && item.fr) begin
                  // both outer sensors on: possible crossing, not a corner
                  st_nxt.lost_run  = '0;
                  st_nxt.cand_run  = '0;
                  st_nxt.cand_dir  = DIR_NONE;
                  st_nxt.ambig_run = amb_inc;
                  res.motor_update = 1'b1;
                  if (amb_inc >= cfg.corner_confirm_count) begin
                    st_nxt.fault = FAULT_AMBIG;
                    st_nxt.mode  = MODE_FAULTED;
                  end
                end else begin
                  st_nxt.ambig_run = '0;
                  if (dir == DIR_NONE) begin
                    st_nxt.cand_dir = DIR_NONE;
                    st_nxt.cand_run = '0;
                    go_lost = 1'b1;
                  end else begin
                    st_nxt.lost_run = '0;
                    st_nxt.cand_dir = dir;
                    if (cand_inc >= cfg.corner_confirm_count) begin
                      st_nxt.armed    = 1'b0;
                      st_nxt.cand_run = '0;
                      if (item.turn_accepts) begin
                        res.turn_request = dir;
                        st_nxt.mode = MODE_TURNING;
                      end else begin
                        st_nxt.fault = FAULT_REQ;
                        st_nxt.mode  = MODE_FAULTED;
                        res.motor_update = 1'b1;
                      end
                    end else begin
                      st_nxt.cand_run  = cand_inc;
                      res.motor_update = 1'b1;
                      res.left_duty    = app_d;
                      res.right_duty   = app_d;
                    end
                  end
                end
              end else begin
                go_lost = 1'b1;
                // re-arm after a clear centred section
                if (clear_pat) begin
                  if (clear_inc >= cfg.corner_confirm_count) begin
                    st_nxt.armed     = 1'b1;
                    st_nxt.clear_run = '0;
                  end else begin
                    st_nxt.clear_run = clear_inc;
                  end
                end else begin
                  st_nxt.clear_run = '0;
                end
              end

              if (go_lost) begin
                res.motor_update = 1'b1;
                if (lost_pat) begin
                  st_nxt.lost_run = lost_inc;
                  if (lost_inc >= cfg.lost_confirm_count) begin
                    st_nxt.fault = FAULT_LOST;
                    st_nxt.mode  = MODE_FAULTED;
                  end else begin
                    res.left_duty  = steer_l;
                    res.right_duty = steer_r;
                  end
                end else begin
                  st_nxt.lost_run = '0;
                  res.left_duty   = steer_l;
                  res.right_duty  = steer_r;
                end
              end
            end
          endcase
        end
      end
      CMD_START: begin
        if (!(st.mode == MODE_FOLLOWING || st.mode == MODE_TURNING ||
              item.turn_status == TS_BUSY)) begin
          st_nxt.turn_total = '0;
          st_nxt.cand_dir   = DIR_NONE;
          st_nxt.cand_run   = '0;
          st_nxt.clear_run  = '0;
          st_nxt.ambig_run  = '0;
          st_nxt.lost_run   = '0;
          st_nxt.armed      = 1'b1;
          st_nxt.fault      = FAULT_NONE;
          st_nxt.mode       = MODE_FOLLOWING;
          res.turn_reset_pulse = 1'b1;
          res.motor_update     = 1'b1;
          res.start_accepted   = 1'b1;
        end
      end
      CMD_HALT: begin
        st_nxt.fault = reason;
        st_nxt.mode  = MODE_FAULTED;
        res.motor_update = 1'b1;
      end
      default: begin
      end
    endcase

    res.mode       = st_nxt.mode;
    res.fault_code = st_nxt.fault;
    res.turns_done = st_nxt.turn_total;
  end

endmodule

// ===== rtl/core/line_follow_corner_supervisor_unit.sv =====
// top level of the line follow corner supervisor: registers, handshake, config
// depends on lfcs_pkg, lfcs_step and assert_macros.svh
`timescale 1ns / 1ps

// Supervisor for a six-sensor line-following robot. Each input word is a
// tick, a start request, an external halt or no command, and yields exactly
// one result word with wheel duties, turn request, turn reset, mode, fault
// code, turn count and start acceptance. Throughput is one word per clock
// while results are taken. Words pass the input register, then the result
// register, with the state updated between them. Input keeps accepting
// while a result waits, until the input register is also full. The user
// must write configuration via cfg_wr_en/cfg_index/cfg_wdata while no word
// is in flight (not enforced); indexes beyond the register list are ignored.

`include "assert_macros.svh"

module line_follow_corner_supervisor_unit import lfcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic        in_front_left_outer,
  input  logic        in_front_right_outer,
  input  logic        in_front_mid_left,
  input  logic        in_front_mid_right,
  input  logic        in_rear_mid_left,
  input  logic        in_rear_mid_right,
  input  logic [1:0]  in_turn_status,
  input  logic        in_turn_accepts,
  input  logic [2:0]  in_halt_reason,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_motor_update,
  output logic [6:0]  out_left_duty,
  output logic [6:0]  out_right_duty,
  output logic [1:0]  out_turn_request,
  output logic        out_turn_reset_pulse,
  output logic [1:0]  out_mode,
  output logic [2:0]  out_fault_code,
  output logic [15:0] out_turns_done,
  output logic        out_start_accepted,

  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t    cfg_r;
  state_t  st_r, st_nxt;
  item_t   item_r;
  result_t res, res_r;
  logic    in_vld_r, out_vld_r;
  logic    advance;

  // the held word moves on when the result register is free or being drained
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.follow_duty          <= FollowDutyRst;
      cfg_r.inner_duty           <= InnerDutyRst;
      cfg_r.approach_duty        <= ApproachDutyRst;
      cfg_r.corner_confirm_count <= CornerConfirmRst;
      cfg_r.lost_confirm_count   <= LostConfirmRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FOLLOW_DUTY:    cfg_r.follow_duty          <= cfg_wdata[DutyW-1:0];
        CFG_INNER_DUTY:     cfg_r.inner_duty           <= cfg_wdata[DutyW-1:0];
        CFG_APPROACH_DUTY:  cfg_r.approach_duty        <= cfg_wdata[DutyW-1:0];
        CFG_CORNER_CONFIRM: cfg_r.corner_confirm_count <= cfg_wdata;
        CFG_LOST_CONFIRM:   cfg_r.lost_confirm_count   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{cmd: in_cmd, fl: in_front_left_outer, fr: in_front_right_outer,
                  fml: in_front_mid_left, fmr: in_front_mid_right,
                  rml: in_rear_mid_left, rmr: in_rear_mid_right,
                  turn_status: in_turn_status, turn_accepts: in_turn_accepts,
                  halt_reason: in_halt_reason};
    end
    if (advance) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{mode: MODE_STOPPED, fault: FAULT_NONE, armed: 1'b0,
                     cand_dir: DIR_NONE, default: '0};
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  lfcs_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign out_valid            = out_vld_r;
  assign out_motor_update     = res_r.motor_update;
  assign out_left_duty        = res_r.left_duty;
  assign out_right_duty       = res_r.right_duty;
  assign out_turn_request     = res_r.turn_request;
  assign out_turn_reset_pulse = res_r.turn_reset_pulse;
  assign out_mode             = res_r.mode;
  assign out_fault_code       = res_r.fault_code;
  assign out_turns_done       = res_r.turns_done;
  assign out_start_accepted   = res_r.start_accepted;

  `LFCS_ASSERT(a_idle_duty_zero, out_vld_r && !res_r.motor_update |-> res_r.left_duty == '0 && res_r.right_duty == '0, "duty without motor update")
  `LFCS_ASSERT(a_duty_limit, out_vld_r |-> res_r.left_duty <= DutyMax && res_r.right_duty <= DutyMax, "duty above limit")
  `LFCS_ASSERT(a_request_turning, out_vld_r && res_r.turn_request != DIR_NONE |-> res_r.mode == MODE_TURNING && !res_r.motor_update, "turn request outside turning")
  `LFCS_ASSERT(a_start_clean, out_vld_r && res_r.start_accepted |-> res_r.mode == MODE_FOLLOWING && res_r.fault_code == FAULT_NONE && res_r.turns_done == '0 && st_r.armed, "start left stale state")
  `LFCS_ASSERT_ALWAYS(a_reset_empty, !$past(rst_n) |-> !in_vld_r && !out_vld_r, "pipeline not empty after reset")

endmodule

// ===== test/tb_line_follow_corner_supervisor_unit.sv =====
// testbench for line_follow_corner_supervisor_unit: directed table, then random words
// checked against an in-bench supervisor predictor; depends on lfcs_pkg and the rtl
`timescale 1ns / 1ps

module tb_line_follow_corner_supervisor_unit;
  import lfcs_pkg::*;

  localparam int HoldCycles = 60;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_LAST  = 3'd7;

  typedef struct {
    item_t   w;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_cmd;
  logic        in_front_left_outer;
  logic        in_front_right_outer;
  logic        in_front_mid_left;
  logic        in_front_mid_right;
  logic        in_rear_mid_left;
  logic        in_rear_mid_right;
  logic [1:0]  in_turn_status;
  logic        in_turn_accepts;
  logic [2:0]  in_halt_reason;
  logic        out_valid;
  logic        out_ready;
  logic        out_motor_update;
  logic [6:0]  out_left_duty;
  logic [6:0]  out_right_duty;
  logic [1:0]  out_turn_request;
  logic        out_turn_reset_pulse;
  logic [1:0]  out_mode;
  logic [2:0]  out_fault_code;
  logic [15:0] out_turns_done;
  logic        out_start_accepted;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // predictor copy of the supervisor state and registers
  mode_t             mode_q;
  logic [2:0]        fault_q;
  logic [CountW-1:0] turns_q;
  logic              armed_q;
  logic [1:0]        cand_dir_q;
  logic [CountW-1:0] cand_run_q;
  logic [CountW-1:0] clear_run_q;
  logic [CountW-1:0] ambig_run_q;
  logic [CountW-1:0] lost_run_q;
  logic [DutyW-1:0]  follow_duty_r;
  logic [DutyW-1:0]  inner_duty_r;
  logic [DutyW-1:0]  approach_duty_r;
  logic [CountW-1:0] corner_cnt_r;
  logic [CountW-1:0] lost_cnt_r;

  stim_row_t word_q[$];
  result_t   pending_results[$];
  result_t   head_want;
  int        mismatch_count;
  int        send_gap_pct;
  int        recv_stall_pct;
  bit        hold_off_req;

  line_follow_corner_supervisor_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_front_left_outer (in_front_left_outer),
    .in_front_right_outer(in_front_right_outer),
    .in_front_mid_left   (in_front_mid_left),
    .in_front_mid_right  (in_front_mid_right),
    .in_rear_mid_left    (in_rear_mid_left),
    .in_rear_mid_right   (in_rear_mid_right),
    .in_turn_status      (in_turn_status),
    .in_turn_accepts     (in_turn_accepts),
    .in_halt_reason      (in_halt_reason),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motor_update    (out_motor_update),
    .out_left_duty       (out_left_duty),
    .out_right_duty      (out_right_duty),
    .out_turn_request    (out_turn_request),
    .out_turn_reset_pulse(out_turn_reset_pulse),
    .out_mode            (out_mode),
    .out_fault_code      (out_fault_code),
    .out_turns_done      (out_turns_done),
    .out_start_accepted  (out_start_accepted),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [CountW-1:0] sat_bump(input logic [CountW-1:0] c);
    return (c == CountMax) ? c : c + 16'd1;
  endfunction

  function automatic void set_wheels(inout result_t r, input logic [DutyW-1:0] l,
                                     input logic [DutyW-1:0] rt);
    r.motor_update = 1'b1;
    r.left_duty    = (l > DutyMax) ? DutyMax : l;
    r.right_duty   = (rt > DutyMax) ? DutyMax : rt;
  endfunction

  function automatic void enter_fault(inout result_t r, input logic [2:0] code);
    fault_q = code;
    mode_q  = MODE_FAULTED;
    set_wheels(r, 7'd0, 7'd0);
  endfunction

  function automatic void drop_runs();
    cand_dir_q  = DIR_NONE;
    cand_run_q  = '0;
    clear_run_q = '0;
    ambig_run_q = '0;
    lost_run_q  = '0;
  endfunction

  // advances the predicted supervisor by one word and returns its result word
  function automatic result_t supervise(input item_t w);
    result_t    r;
    logic [1:0] dir;
    logic       steer_on;
    r = '0;
    dir = DIR_NONE;
    steer_on = 1'b0;
    case (w.cmd)
      CMD_TICK: begin
        if (mode_q == MODE_STOPPED || mode_q == MODE_FAULTED) begin
          set_wheels(r, 7'd0, 7'd0);
        end else if (w.turn_status == TS_FAULT) begin
          enter_fault(r, FAULT_TURN);
        end else if (w.turn_status == TS_DONE) begin
          turns_q = sat_bump(turns_q);
          r.turn_reset_pulse = 1'b1;
          mode_q = MODE_FOLLOWING;
          armed_q = 1'b0;
          drop_runs();
        end else if (w.turn_status == TS_BUSY) begin
          mode_q = MODE_TURNING;
        end else begin
          steer_on = 1'b1;
          if (armed_q) begin
            if (w.fl && w.fr) begin
              steer_on = 1'b0;
              lost_run_q = '0;
              cand_run_q = '0;
              cand_dir_q = DIR_NONE;
              ambig_run_q = sat_bump(ambig_run_q);
              if (ambig_run_q >= corner_cnt_r) enter_fault(r, FAULT_AMBIG);
              else set_wheels(r, 7'd0, 7'd0);
            end else begin
              ambig_run_q = '0;
              if (w.rml && w.rmr) dir = w.fl ? DIR_LEFT : (w.fr ? DIR_RIGHT : DIR_NONE);
              if (dir == DIR_NONE) begin
                cand_dir_q = DIR_NONE;
                cand_run_q = '0;
              end else begin
                steer_on = 1'b0;
                lost_run_q = '0;
                if (cand_dir_q != dir) begin
                  cand_dir_q = dir;
                  cand_run_q = '0;
                end
                cand_run_q = sat_bump(cand_run_q);
                if (cand_run_q >= corner_cnt_r) begin
                  armed_q = 1'b0;
                  cand_run_q = '0;
                  if (w.turn_accepts) begin
                    r.turn_request = dir;
                    mode_q = MODE_TURNING;
                  end else begin
                    enter_fault(r, FAULT_REQ);
                  end
                end else begin
                  set_wheels(r, approach_duty_r, approach_duty_r);
                end
              end
            end
          end else if (!w.fl && !w.fr && w.fml && w.fmr && w.rml && w.rmr) begin
            // centred clear section re-arms corner detection
            clear_run_q = sat_bump(clear_run_q);
            if (clear_run_q >= corner_cnt_r) begin
              armed_q = 1'b1;
              clear_run_q = '0;
            end
          end else begin
            clear_run_q = '0;
          end
          if (steer_on) begin
            if (!w.fml && !w.fmr && !(w.rml && w.rmr)) begin
              lost_run_q = sat_bump(lost_run_q);
              if (lost_run_q >= lost_cnt_r) begin
                enter_fault(r, FAULT_LOST);
                steer_on = 1'b0;
              end
            end else begin
              lost_run_q = '0;
            end
          end
          if (steer_on) begin
            if (w.fml && w.fmr) set_wheels(r, follow_duty_r, follow_duty_r);
            else if (w.fml) set_wheels(r, inner_duty_r, follow_duty_r);
            else if (w.fmr) set_wheels(r, follow_duty_r, inner_duty_r);
            else if (w.rml && w.rmr) set_wheels(r, approach_duty_r, approach_duty_r);
            else set_wheels(r, 7'd0, 7'd0);
          end
        end
      end
      CMD_START: begin
        if (!(mode_q == MODE_FOLLOWING || mode_q == MODE_TURNING ||
              w.turn_status == TS_BUSY)) begin
          r.turn_reset_pulse = 1'b1;
          turns_q = '0;
          drop_runs();
          armed_q = 1'b1;
          fault_q = FAULT_NONE;
          mode_q = MODE_FOLLOWING;
          set_wheels(r, 7'd0, 7'd0);
          r.start_accepted = 1'b1;
        end
      end
      CMD_HALT: begin
        enter_fault(r, (w.halt_reason > FAULT_LOST) ? FAULT_LOST : w.halt_reason);
      end
      default: ;
    endcase
    r.mode = mode_q;
    r.fault_code = fault_q;
    r.turns_done = turns_q;
    return r;
  endfunction

  function automatic bit rb();
    return bit'($urandom_range(1));
  endfunction

  function automatic item_t tick_w(input bit fl, input bit fr, input bit fml, input bit fmr,
                                   input bit rml, input bit rmr, input logic [1:0] ts,
                                   input bit acc);
    item_t w;
    w.cmd = CMD_TICK;
    w.fl = fl;
    w.fr = fr;
    w.fml = fml;
    w.fmr = fmr;
    w.rml = rml;
    w.rmr = rmr;
    w.turn_status = ts;
    w.turn_accepts = acc;
    w.halt_reason = 3'($urandom_range(7));
    return w;
  endfunction

  function automatic item_t cmd_w(input cmd_t c, input logic [1:0] ts, input logic [2:0] reason);
    item_t w;
    w = tick_w(rb(), rb(), rb(), rb(), rb(), rb(), ts, rb());
    w.cmd = c;
    w.halt_reason = reason;
    return w;
  endfunction

  function automatic result_t outcome(input bit mu, input logic [6:0] l, input logic [6:0] rt,
                                      input logic [1:0] req, input bit rst, input mode_t m,
                                      input logic [2:0] f, input logic [15:0] t, input bit acc);
    result_t r;
    r.motor_update = mu;
    r.left_duty = l;
    r.right_duty = rt;
    r.turn_request = req;
    r.turn_reset_pulse = rst;
    r.mode = m;
    r.fault_code = f;
    r.turns_done = t;
    r.start_accepted = acc;
    return r;
  endfunction

  function automatic int run_len(input logic [CountW-1:0] n);
    return (n == 0) ? 1 : ((n > 6) ? 6 : int'(n));
  endfunction

  task automatic add_row(input item_t w, input bit typed, input result_t want);
    stim_row_t row;
    row.w = w;
    row.typed = typed;
    row.want = want;
    word_q.push_back(row);
  endtask

  // one random scenario; most are well-formed sequences with random content
  task automatic add_scenario();
    int pick;
    int k;
    bit side;
    pick = $urandom_range(99);
    k = run_len(corner_cnt_r);
    if (pick < 10) begin
      add_row(cmd_w(CMD_START, 2'($urandom_range(3)), 3'($urandom_range(7))), 1'b0, '0);
    end else if (pick < 35) begin
      side = rb();
      repeat (k) add_row(tick_w(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, TS_IDLE, rb()),
                         1'b0, '0);
      repeat (k) add_row(tick_w(side, !side, rb(), rb(), 1'b1, 1'b1, TS_IDLE,
                               $urandom_range(4) != 0), 1'b0, '0);
      repeat ($urandom_range(2)) add_row(tick_w(rb(), rb(), rb(), rb(), rb(), rb(),
                                                TS_BUSY, rb()), 1'b0, '0);
      add_row(tick_w(rb(), rb(), rb(), rb(), rb(), rb(),
                     ($urandom_range(9) == 0) ? TS_FAULT : TS_DONE, rb()), 1'b0, '0);
    end else if (pick < 50) begin
      repeat (k) add_row(tick_w(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, TS_IDLE, rb()),
                         1'b0, '0);
      repeat (1 + $urandom_range(3)) add_row(tick_w(1'b0, 1'b0, rb(), rb(), rb(), rb(),
                                                    TS_IDLE, rb()), 1'b0, '0);
    end else if (pick < 58) begin
      repeat (k) add_row(tick_w(1'b1, 1'b1, rb(), rb(), rb(), rb(), TS_IDLE, rb()),
                         1'b0, '0);
    end else if (pick < 66) begin
      repeat (run_len(lost_cnt_r)) add_row(tick_w(1'b0, 1'b0, 1'b0, 1'b0, rb(), 1'b0,
                                                  TS_IDLE, rb()), 1'b0, '0);
    end else if (pick < 72) begin
      add_row(cmd_w(CMD_HALT, 2'($urandom_range(3)), 3'($urandom_range(7))), 1'b0, '0);
    end else if (pick < 80) begin
      repeat (1 + $urandom_range(2)) add_row(tick_w(rb(), rb(), rb(), rb(), rb(), rb(),
                                                    2'($urandom_range(3)), rb()), 1'b0, '0);
    end else begin
      repeat (1 + $urandom_range(2)) add_row(cmd_w(cmd_t'($urandom_range(3)),
                                                   2'($urandom_range(3)),
                                                   3'($urandom_range(7))), 1'b0, '0);
    end
  endtask

  task automatic gen_random(input int n);
    while (word_q.size() < n) add_scenario();
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_FOLLOW_DUTY:    follow_duty_r = val[DutyW-1:0];
      CFG_INNER_DUTY:     inner_duty_r = val[DutyW-1:0];
      CFG_APPROACH_DUTY:  approach_duty_r = val[DutyW-1:0];
      CFG_CORNER_CONFIRM: corner_cnt_r = val;
      CFG_LOST_CONFIRM:   lost_cnt_r = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] f, input logic [15:0] i, input logic [15:0] a,
                            input logic [15:0] c, input logic [15:0] l);
    write_reg(CFG_FOLLOW_DUTY, f);
    write_reg(CFG_INNER_DUTY, i);
    write_reg(CFG_APPROACH_DUTY, a);
    write_reg(CFG_CORNER_CONFIRM, c);
    write_reg(CFG_LOST_CONFIRM, l);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sends every queued word and records its predicted result on acceptance
  task automatic run_words();
    stim_row_t row;
    result_t   want;
    while (word_q.size() != 0) begin
      row = word_q.pop_front();
      @(negedge clk);
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid <= 1'b1;
      in_cmd <= row.w.cmd;
      in_front_left_outer <= row.w.fl;
      in_front_right_outer <= row.w.fr;
      in_front_mid_left <= row.w.fml;
      in_front_mid_right <= row.w.fmr;
      in_rear_mid_left <= row.w.rml;
      in_rear_mid_right <= row.w.rmr;
      in_turn_status <= row.w.turn_status;
      in_turn_accepts <= row.w.turn_accepts;
      in_halt_reason <= row.w.halt_reason;
      do @(posedge clk); while (!in_ready);
      want = supervise(row.w);
      pending_results.push_back(row.typed ? row.want : want);
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      mismatch_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", name, got, want, $realtime);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        check_field("word with nothing pending", 16'd1, 16'd0);
      end else begin
        head_want = pending_results.pop_front();
        check_field("motor_update", 16'(out_motor_update), 16'(head_want.motor_update));
        check_field("left_duty", 16'(out_left_duty), 16'(head_want.left_duty));
        check_field("right_duty", 16'(out_right_duty), 16'(head_want.right_duty));
        check_field("turn_request", 16'(out_turn_request), 16'(head_want.turn_request));
        check_field("turn_reset_pulse", 16'(out_turn_reset_pulse),
                    16'(head_want.turn_reset_pulse));
        check_field("mode", 16'(out_mode), 16'(head_want.mode));
        check_field("fault_code", 16'(out_fault_code), 16'(head_want.fault_code));
        check_field("turns_done", out_turns_done, head_want.turns_done);
        check_field("start_accepted", 16'(out_start_accepted),
                    16'(head_want.start_accepted));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : main
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_TICK;
    in_front_left_outer = 1'b0;
    in_front_right_outer = 1'b0;
    in_front_mid_left = 1'b0;
    in_front_mid_right = 1'b0;
    in_rear_mid_left = 1'b0;
    in_rear_mid_right = 1'b0;
    in_turn_status = TS_IDLE;
    in_turn_accepts = 1'b0;
    in_halt_reason = FAULT_NONE;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_FOLLOW_DUTY;
    cfg_wdata = '0;
    mismatch_count = 0;
    hold_off_req = 1'b0;
    send_gap_pct = 13;
    recv_stall_pct = 81;
    mode_q = MODE_STOPPED;
    fault_q = FAULT_NONE;
    turns_q = '0;
    armed_q = 1'b0;
    drop_runs();
    follow_duty_r = FollowDutyRst;
    inner_duty_r = InnerDutyRst;
    approach_duty_r = ApproachDutyRst;
    corner_cnt_r = CornerConfirmRst;
    lost_cnt_r = LostConfirmRst;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    add_row(tick_w(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, TS_IDLE, 1'b1), 1'b1,
            outcome(1'b1, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_STOPPED, FAULT_NONE, 16'd0, 1'b0));
    add_row(cmd_w(CMD_NONE, TS_IDLE, 3'd1), 1'b1,
            outcome(1'b0, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_STOPPED, FAULT_NONE, 16'd0, 1'b0));
    add_row(cmd_w(CMD_HALT, TS_IDLE, 3'd0), 1'b1,
            outcome(1'b1, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_FAULTED, FAULT_NONE, 16'd0, 1'b0));
    add_row(cmd_w(CMD_HALT, TS_IDLE, 3'd7), 1'b1,
            outcome(1'b1, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_FAULTED, FAULT_LOST, 16'd0, 1'b0));
    add_row(cmd_w(CMD_START, TS_BUSY, 3'd2), 1'b1,
            outcome(1'b0, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_FAULTED, FAULT_LOST, 16'd0, 1'b0));
    add_row(cmd_w(CMD_START, TS_IDLE, 3'd4), 1'b1,
            outcome(1'b1, 7'd0, 7'd0, DIR_NONE, 1'b1, MODE_FOLLOWING, FAULT_NONE, 16'd0,
                    1'b1));
    add_row(cmd_w(CMD_START, TS_DONE, 3'd1), 1'b1,
            outcome(1'b0, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_FOLLOWING, FAULT_NONE, 16'd0,
                    1'b0));
    add_row(tick_w(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, TS_IDLE, 1'b1), 1'b0, '0);
    add_row(tick_w(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, TS_IDLE, 1'b0), 1'b0, '0);
    add_row(tick_w(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, TS_IDLE, 1'b1), 1'b0, '0);
    add_row(tick_w(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, TS_IDLE, 1'b0), 1'b0, '0);
    add_row(tick_w(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, TS_IDLE, 1'b1), 1'b0, '0);
    repeat (4) add_row(tick_w(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, TS_IDLE, 1'b1), 1'b0, '0);
    // turning with an idle turn unit keeps the mode
    add_row(tick_w(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, TS_IDLE, 1'b0), 1'b0, '0);
    add_row(tick_w(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, TS_BUSY, 1'b1), 1'b0, '0);
    add_row(tick_w(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, TS_DONE, 1'b0), 1'b0, '0);
    add_row(tick_w(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, TS_FAULT, 1'b1), 1'b1,
            outcome(1'b1, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_FAULTED, FAULT_TURN, 16'd1, 1'b0));
    add_row(cmd_w(CMD_START, TS_FAULT, 3'd5), 1'b1,
            outcome(1'b1, 7'd0, 7'd0, DIR_NONE, 1'b1, MODE_FOLLOWING, FAULT_NONE, 16'd0,
                    1'b1));
    repeat (3) add_row(tick_w(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, TS_IDLE, 1'b1), 1'b0, '0);
    add_row(tick_w(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, TS_IDLE, 1'b0), 1'b1,
            outcome(1'b1, 7'd0, 7'd0, DIR_NONE, 1'b0, MODE_FAULTED, FAULT_AMBIG, 16'd0, 1'b0));
    run_words();
    drain();

    set_config(16'd100, 16'd0, 16'd0, 16'd2, 16'd2);
    gen_random(150);
    run_words();
    drain();

    send_gap_pct = 81;
    recv_stall_pct = 13;
    // duty above 100 with junk in the upper data bits, and confirm counts below 2
    set_config(16'h3F7F, 16'd99, 16'd127, 16'd0, 16'd1);
    hold_off_req = 1'b1;
    gen_random(150);
    run_words();
    drain();

    write_reg(CFG_UNUSED_FIRST, 16'($urandom));
    write_reg(CFG_UNUSED_LAST, 16'($urandom));
    set_config(16'd1, 16'd0, 16'd55, 16'd3, 16'd65535);
    gen_random(150);
    run_words();
    drain();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_config(16'd73, 16'd35, 16'd100, 16'd65535, 16'd6);
    gen_random(120);
    run_words();
    drain();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== line_follow_corner_supervisor_unit.f =====
+incdir+rtl/core
rtl/core/lfcs_pkg.sv
rtl/core/lfcs_step.sv
rtl/core/line_follow_corner_supervisor_unit.sv
test/tb_line_follow_corner_supervisor_unit.sv
